@@ sv/ssc_pkg.sv @@
package ssc_pkg;

  localparam int DIGITS = 4;
  localparam int STORE_DEPTH = 4;

  typedef logic [2:0]  step_t;
  typedef logic [13:0] period_t;
  typedef logic [15:0] level_t;
  typedef logic [3:0]  digit_t;
  typedef logic [2:0]  dcount_t;
  typedef logic [1:0]  cfg_idx_t;

  localparam step_t   STEP_LAST    = 3'd5;
  localparam period_t RESET_PERIOD = 14'd5000;
  localparam level_t  RESET_DUTY   = 16'd2000;
  localparam level_t  RESET_FULL   = 16'd800;

  localparam cfg_idx_t CFG_DUTY = 2'd0;
  localparam cfg_idx_t CFG_FULL = 2'd1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] HS_U = 3'b001;
  localparam logic [2:0] HS_V = 3'b010;
  localparam logic [2:0] HS_W = 3'b100;

  typedef struct packed {
    step_t   step;
    period_t period;
  } core_status_t;

endpackage

@@ sv/ssc_state.sv @@
module ssc_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  mode,
  input  logic [7:0]            rx_byte,
  output ssc_pkg::core_status_t status_nxt
);
  import ssc_pkg::*;

  step_t   step_r, step_nxt;
  period_t ticks_r, ticks_nxt;
  period_t period_r, period_nxt;
  dcount_t dcount_r, dcount_nxt;
  digit_t  store_r [STORE_DEPTH];
  digit_t  store_view [STORE_DEPTH];

  logic    is_digit;
  digit_t  digit_val;
  dcount_t cnt_after;
  period_t number;

  always_comb begin
    is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    digit_val = 4'(rx_byte - CHAR_ZERO);
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_view[k] = store_r[k];
    end
    if (is_digit) begin
      store_view[dcount_r[1:0]] = digit_val;
    end
    cnt_after = is_digit ? dcount_t'(dcount_r + 3'd1) : dcount_r;
    number = '0;
    for (int k = 0; k < DIGITS; k++) begin
      number = period_t'((number << 3) + (number << 1) + period_t'(store_view[k]));
    end

    step_nxt   = step_r;
    ticks_nxt  = ticks_r;
    period_nxt = period_r;
    dcount_nxt = dcount_r;
    if (!mode) begin
      if (ticks_r <= period_t'(1)) begin
        step_nxt  = (step_r == STEP_LAST) ? '0 : step_t'(step_r + 3'd1);
        ticks_nxt = period_r;
      end else begin
        ticks_nxt = period_t'(ticks_r - 14'd1);
      end
    end else begin
      dcount_nxt = cnt_after;
      if (cnt_after >= dcount_t'(DIGITS)) begin
        dcount_nxt = '0;
        if (number != '0) begin
          period_nxt = number;
        end
      end
    end

    status_nxt.step   = step_nxt;
    status_nxt.period = period_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      ticks_r  <= RESET_PERIOD;
      period_r <= RESET_PERIOD;
      dcount_r <= '0;
    end else if (fire) begin
      step_r   <= step_nxt;
      ticks_r  <= ticks_nxt;
      period_r <= period_nxt;
      dcount_r <= dcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mode && is_digit) begin
      store_r[dcount_r[1:0]] <= digit_val;
    end
  end

endmodule

@@ sv/ssc_out_stage.sv @@
module ssc_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  ssc_pkg::core_status_t status_nxt,
  input  ssc_pkg::level_t       duty_level,
  input  ssc_pkg::level_t       full_level,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  can_load,
  output ssc_pkg::step_t        out_phase_step,
  output logic [2:0]            out_high_side_enable,
  output ssc_pkg::level_t       out_compare_u,
  output ssc_pkg::level_t       out_compare_v,
  output ssc_pkg::level_t       out_compare_w,
  output ssc_pkg::period_t      out_step_period
);
  import ssc_pkg::*;

  logic       valid_r;
  step_t      step_r;
  logic [2:0] hs_r, hs_nxt;
  level_t     u_r, v_r, w_r, u_nxt, v_nxt, w_nxt;
  period_t    period_r;

  always_comb begin
    unique case (status_nxt.step)
      3'd0: begin u_nxt = duty_level; v_nxt = full_level; w_nxt = '0; hs_nxt = HS_U; end
      3'd1: begin u_nxt = duty_level; v_nxt = '0; w_nxt = full_level; hs_nxt = HS_U; end
      3'd2: begin u_nxt = '0; v_nxt = duty_level; w_nxt = full_level; hs_nxt = HS_V; end
      3'd3: begin u_nxt = full_level; v_nxt = duty_level; w_nxt = '0; hs_nxt = HS_V; end
      3'd4: begin u_nxt = full_level; v_nxt = '0; w_nxt = duty_level; hs_nxt = HS_W; end
      default: begin u_nxt = '0; v_nxt = full_level; w_nxt = duty_level; hs_nxt = HS_W; end
    endcase
  end

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_r   <= status_nxt.step;
      period_r <= status_nxt.period;
      hs_r     <= hs_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      w_r      <= w_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_phase_step       = step_r;
  assign out_high_side_enable = hs_r;
  assign out_compare_u        = u_r;
  assign out_compare_v        = v_r;
  assign out_compare_w        = w_r;
  assign out_step_period      = period_r;

endmodule

@@ sv/six_step_commutator_serial_speed_unit.sv @@
// Open-loop six-step commutator with a serial speed setting.
// Input channel (in_valid/in_ready): in_mode 0 is one time tick, in_mode 1
// carries one received character on in_rx_byte. Digit characters collect
// into a four-digit decimal step period; other characters are dropped.
// Result channel (out_valid/out_ready): one item per input item, with the
// step, one-hot high-side enable, three phase compare values and the period.
// Configuration: cfg_we writes cfg_wdata to duty level (index 0) or full
// level (index 1) at once; other indexes are dropped. Write only when idle.
// An accepted item passes the input register, then the result register, before
// out_valid rises. Throughput: one item per cycle while the receiver does not
// stall, set by the combinational state update between the two registers.
// Reset: step 0, countdown and period 5000, digit count 0, duty 2000, full
// 800; no items held. When the receiver stalls, the result register holds,
// the input register still takes one more item, and in_ready then drops.
module six_step_commutator_serial_speed_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssc_pkg::step_t        out_phase_step,
  output logic [2:0]            out_high_side_enable,
  output ssc_pkg::level_t       out_compare_u,
  output ssc_pkg::level_t       out_compare_v,
  output ssc_pkg::level_t       out_compare_w,
  output ssc_pkg::period_t      out_step_period,
  input  logic                  cfg_we,
  input  ssc_pkg::cfg_idx_t     cfg_index,
  input  ssc_pkg::level_t       cfg_wdata
);
  import ssc_pkg::*;

  logic         s1_valid_r;
  logic         s1_mode_r;
  logic [7:0]   s1_byte_r;
  logic         can_load;
  logic         fire;
  level_t       duty_r, full_r;
  core_status_t status_nxt;

  assign fire     = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= RESET_DUTY;
      full_r <= RESET_FULL;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DUTY) begin
        duty_r <= cfg_wdata;
      end
      if (cfg_index == CFG_FULL) begin
        full_r <= cfg_wdata;
      end
    end
  end

  ssc_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .mode       (s1_mode_r),
    .rx_byte    (s1_byte_r),
    .status_nxt (status_nxt)
  );

  ssc_out_stage u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fire                 (fire),
    .status_nxt           (status_nxt),
    .duty_level           (duty_r),
    .full_level           (full_r),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .can_load             (can_load),
    .out_phase_step       (out_phase_step),
    .out_high_side_enable (out_high_side_enable),
    .out_compare_u        (out_compare_u),
    .out_compare_v        (out_compare_v),
    .out_compare_w        (out_compare_w),
    .out_step_period      (out_step_period)
  );

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase_step <= STEP_LAST)
    else $error("step out of range");

  a_hs_matches_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_high_side_enable == (3'b001 << out_phase_step[2:1])))
    else $error("high-side enable does not match step");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_step_period != '0)
    else $error("zero step period");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !fire) |=> s1_valid_r)
    else $error("pending item lost");
`endif

endmodule
